### rtl/npl_pkg.sv
// Package with register map constants shared by the nearest point to line block.
`default_nettype none

package npl_pkg;

	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;

	typedef enum logic [2:0] {
		REG_ANCHOR_X = 3'd0,
		REG_ANCHOR_Y = 3'd1,
		REG_ANCHOR_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5
	} reg_idx_t;

endpackage

`default_nettype wire

### rtl/npl_regs.sv
// APB configuration registers holding the line anchor and direction.
`default_nettype none

module npl_regs #(
	parameter int COORD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [npl_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [npl_pkg::DATA_BITS-1:0]   pwdata,
	output logic [npl_pkg::DATA_BITS-1:0]   prdata,
	output logic                            pready,
	output logic signed [COORD_BITS-1:0]    anchor_x,
	output logic signed [COORD_BITS-1:0]    anchor_y,
	output logic signed [COORD_BITS-1:0]    anchor_z,
	output logic signed [COORD_BITS-1:0]    dir_x,
	output logic signed [COORD_BITS-1:0]    dir_y,
	output logic signed [COORD_BITS-1:0]    dir_z
);
	import npl_pkg::*;

	logic                         wr_en;
	reg_idx_t                     idx;
	logic signed [COORD_BITS-1:0] wdata;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign wdata  = $signed(pwdata[COORD_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_x <= '0;
			anchor_y <= '0;
			anchor_z <= '0;
			dir_x    <= COORD_BITS'(1);
			dir_y    <= '0;
			dir_z    <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_ANCHOR_X: anchor_x <= wdata;
				REG_ANCHOR_Y: anchor_y <= wdata;
				REG_ANCHOR_Z: anchor_z <= wdata;
				REG_DIR_X:    dir_x    <= wdata;
				REG_DIR_Y:    dir_y    <= wdata;
				REG_DIR_Z:    dir_z    <= wdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ANCHOR_X: prdata = DATA_BITS'(anchor_x);
			REG_ANCHOR_Y: prdata = DATA_BITS'(anchor_y);
			REG_ANCHOR_Z: prdata = DATA_BITS'(anchor_z);
			REG_DIR_X:    prdata = DATA_BITS'(dir_x);
			REG_DIR_Y:    prdata = DATA_BITS'(dir_y);
			REG_DIR_Z:    prdata = DATA_BITS'(dir_z);
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/npl_score.sv
// Front scoring pipeline computing the squared cross product score of each point.
`default_nettype none

module npl_score #(
	parameter int COORD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic signed [COORD_BITS-1:0]         point_x,
	input  logic signed [COORD_BITS-1:0]         point_y,
	input  logic signed [COORD_BITS-1:0]         point_z,
	input  logic                                 last,
	input  logic signed [COORD_BITS-1:0]         anchor_x,
	input  logic signed [COORD_BITS-1:0]         anchor_y,
	input  logic signed [COORD_BITS-1:0]         anchor_z,
	input  logic signed [COORD_BITS-1:0]         dir_x,
	input  logic signed [COORD_BITS-1:0]         dir_y,
	input  logic signed [COORD_BITS-1:0]         dir_z,
	output logic                                 push,
	output logic [4*COORD_BITS+3:0]              score,
	output logic [COORD_BITS-1:0]                pt_x,
	output logic [COORD_BITS-1:0]                pt_y,
	output logic [COORD_BITS-1:0]                pt_z,
	output logic                                 pt_last
);
	localparam int W        = COORD_BITS;
	localparam int LO_BITS  = W + 1;
	localparam int SQ_BITS  = 4 * W + 2;
	localparam int SC_BITS  = 4 * W + 4;
	localparam int PT_BITS  = 3 * W + 1;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [PT_BITS-1:0] pt_s1, pt_s2, pt_s3, pt_s4, pt_s5;

	logic signed [W:0]     hx_s1, hy_s1, hz_s1;
	logic signed [2*W:0]   pa_s2, pb_s2, pc_s2, pd_s2, pe_s2, pf_s2;
	logic signed [2*W+1:0] c0, c1, c2, n0, n1, n2;
	logic [2*W:0]          m0_s3, m1_s3, m2_s3;
	logic [2*W-1:0]        hh0_s4, hh1_s4, hh2_s4;
	logic [2*W:0]          hl0_s4, hl1_s4, hl2_s4;
	logic [2*W+1:0]        ll0_s4, ll1_s4, ll2_s4;
	logic [SQ_BITS-1:0]    sq0_s5, sq1_s5, sq2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		c0 = pa_s2 - pb_s2;
		c1 = pc_s2 - pd_s2;
		c2 = pe_s2 - pf_s2;
		n0 = -c0;
		n1 = -c1;
		n2 = -c2;
	end

	always_ff @(posedge clk) begin
		pt_s1 <= {last, point_z, point_y, point_x};
		hx_s1 <= point_x - anchor_x;
		hy_s1 <= point_y - anchor_y;
		hz_s1 <= point_z - anchor_z;

		pt_s2 <= pt_s1;
		pa_s2 <= dir_y * hz_s1;
		pb_s2 <= dir_z * hy_s1;
		pc_s2 <= dir_z * hx_s1;
		pd_s2 <= dir_x * hz_s1;
		pe_s2 <= dir_x * hy_s1;
		pf_s2 <= dir_y * hx_s1;

		pt_s3 <= pt_s2;
		m0_s3 <= c0[2*W+1] ? n0[2*W:0] : c0[2*W:0];
		m1_s3 <= c1[2*W+1] ? n1[2*W:0] : c1[2*W:0];
		m2_s3 <= c2[2*W+1] ? n2[2*W:0] : c2[2*W:0];

		pt_s4  <= pt_s3;
		hh0_s4 <= m0_s3[2*W:LO_BITS] * m0_s3[2*W:LO_BITS];
		hh1_s4 <= m1_s3[2*W:LO_BITS] * m1_s3[2*W:LO_BITS];
		hh2_s4 <= m2_s3[2*W:LO_BITS] * m2_s3[2*W:LO_BITS];
		hl0_s4 <= m0_s3[2*W:LO_BITS] * m0_s3[LO_BITS-1:0];
		hl1_s4 <= m1_s3[2*W:LO_BITS] * m1_s3[LO_BITS-1:0];
		hl2_s4 <= m2_s3[2*W:LO_BITS] * m2_s3[LO_BITS-1:0];
		ll0_s4 <= m0_s3[LO_BITS-1:0] * m0_s3[LO_BITS-1:0];
		ll1_s4 <= m1_s3[LO_BITS-1:0] * m1_s3[LO_BITS-1:0];
		ll2_s4 <= m2_s3[LO_BITS-1:0] * m2_s3[LO_BITS-1:0];

		pt_s5  <= pt_s4;
		sq0_s5 <= (SQ_BITS'(hh0_s4) << (2 * LO_BITS)) + (SQ_BITS'(hl0_s4) << (LO_BITS + 1))
			+ SQ_BITS'(ll0_s4);
		sq1_s5 <= (SQ_BITS'(hh1_s4) << (2 * LO_BITS)) + (SQ_BITS'(hl1_s4) << (LO_BITS + 1))
			+ SQ_BITS'(ll1_s4);
		sq2_s5 <= (SQ_BITS'(hh2_s4) << (2 * LO_BITS)) + (SQ_BITS'(hl2_s4) << (LO_BITS + 1))
			+ SQ_BITS'(ll2_s4);
	end

	assign push    = v_s5;
	assign score   = SC_BITS'(sq0_s5) + SC_BITS'(sq1_s5) + SC_BITS'(sq2_s5);
	assign pt_x    = pt_s5[W-1:0];
	assign pt_y    = pt_s5[2*W-1:W];
	assign pt_z    = pt_s5[3*W-1:2*W];
	assign pt_last = pt_s5[3*W];

endmodule

`default_nettype wire

### rtl/npl_queue.sv
// Credit-managed queue between the scoring pipeline and the selection stage.
`default_nettype none

module npl_queue #(
	parameter int COORD_BITS  = 16,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      reserve,
	input  logic                      push,
	input  logic [4*COORD_BITS+3:0]   push_score,
	input  logic [COORD_BITS-1:0]     push_x,
	input  logic [COORD_BITS-1:0]     push_y,
	input  logic [COORD_BITS-1:0]     push_z,
	input  logic                      push_last,
	input  logic                      pop,
	output logic                      full,
	output logic                      not_empty,
	output logic [4*COORD_BITS+3:0]   head_score,
	output logic [COORD_BITS-1:0]     head_x,
	output logic [COORD_BITS-1:0]     head_y,
	output logic [COORD_BITS-1:0]     head_z,
	output logic                      head_last
);
	localparam int W        = COORD_BITS;
	localparam int SC_BITS  = 4 * W + 4;
	localparam int E_BITS   = SC_BITS + 3 * W + 1;
	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	logic [E_BITS-1:0]   entry_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] credit_q, stored_q;
	logic [E_BITS-1:0]   head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			credit_q <= '0;
			stored_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (reserve && !pop) begin
				credit_q <= credit_q + 1'b1;
			end else if (!reserve && pop) begin
				credit_q <= credit_q - 1'b1;
			end
			if (push && !pop) begin
				stored_q <= stored_q + 1'b1;
			end else if (!push && pop) begin
				stored_q <= stored_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= {push_last, push_z, push_y, push_x, push_score};
		end
	end

	assign head       = entry_q[rd_ptr_q];
	assign full       = (credit_q == CNT_BITS'(QUEUE_DEPTH));
	assign not_empty  = (stored_q != '0);
	assign head_score = head[SC_BITS-1:0];
	assign head_x     = head[SC_BITS+W-1:SC_BITS];
	assign head_y     = head[SC_BITS+2*W-1:SC_BITS+W];
	assign head_z     = head[SC_BITS+3*W-1:SC_BITS+2*W];
	assign head_last  = head[E_BITS-1];

	a_stored_within_credit: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= credit_q)
		else $error("queue holds more entries than credits issued");

	a_push_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> stored_q < credit_q)
		else $error("queue push without an outstanding credit");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stored_q != '0)
		else $error("queue pop while empty");

endmodule

`default_nettype wire

### rtl/npl_select.sv
// Back stage keeping the best point of a set and holding the result register.
`default_nettype none

module npl_select #(
	parameter int COORD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  logic [4*COORD_BITS+3:0]         head_score,
	input  logic [COORD_BITS-1:0]           head_x,
	input  logic [COORD_BITS-1:0]           head_y,
	input  logic [COORD_BITS-1:0]           head_z,
	input  logic                            head_last,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [COORD_BITS-1:0]    near_x,
	output logic signed [COORD_BITS-1:0]    near_y,
	output logic signed [COORD_BITS-1:0]    near_z
);
	logic                    have_best_q;
	logic [4*COORD_BITS+3:0] best_score_q;
	logic [COORD_BITS-1:0]   best_x_q, best_y_q, best_z_q;
	logic                    out_valid_q;
	logic                    better;
	logic [COORD_BITS-1:0]   win_x, win_y, win_z;

	assign pop    = head_valid && (!out_valid_q || !out_stall);
	assign better = !have_best_q || (head_score < best_score_q);
	assign win_x  = better ? head_x : best_x_q;
	assign win_y  = better ? head_y : best_y_q;
	assign win_z  = better ? head_z : best_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				have_best_q <= !head_last;
			end
			if (pop && head_last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && better) begin
			best_score_q <= head_score;
			best_x_q     <= head_x;
			best_y_q     <= head_y;
			best_z_q     <= head_z;
		end
		if (pop && head_last) begin
			near_x <= $signed(win_x);
			near_y <= $signed(win_y);
			near_z <= $signed(win_z);
		end
	end

	assign out_valid = out_valid_q;

	a_last_clears_best: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head_last |=> !have_best_q)
		else $error("best point not cleared after the last point of a set");

	a_no_pop_into_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !pop)
		else $error("queue popped while a result transfer is stalled");

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pop && head_last))
		else $error("result raised without a last point");

endmodule

`default_nettype wire

### rtl/nearest_point_to_line.sv
// Top level: one point per cycle while in_stall is low; one result per set follows its last point.
// Throughput is one point per cycle while in_stall is low, set by the five-stage scoring
// pipeline and the credit loop through the QUEUE_DEPTH-entry queue; every accepted point
// takes a credit, so in_stall rises when scored and queued points hold all of them.
// Reset clears all control state, restores the anchor to zero and the direction to (1,0,0),
// and discards any partly collected set.
`default_nettype none

module nearest_point_to_line #(
	parameter int COORD_BITS  = 16,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [npl_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [npl_pkg::DATA_BITS-1:0]   pwdata,
	output logic [npl_pkg::DATA_BITS-1:0]   prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [COORD_BITS-1:0]    point_x,
	input  logic signed [COORD_BITS-1:0]    point_y,
	input  logic signed [COORD_BITS-1:0]    point_z,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [COORD_BITS-1:0]    near_x,
	output logic signed [COORD_BITS-1:0]    near_y,
	output logic signed [COORD_BITS-1:0]    near_z
);
	import npl_pkg::*;

	logic signed [COORD_BITS-1:0] anchor_x, anchor_y, anchor_z, dir_x, dir_y, dir_z;
	logic                         accept;
	logic                         push, push_last, pop, q_full, q_valid, head_last;
	logic [4*COORD_BITS+3:0]      push_score, head_score;
	logic [COORD_BITS-1:0]        push_x, push_y, push_z, head_x, head_y, head_z;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	npl_regs #(.COORD_BITS(COORD_BITS)) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.anchor_x (anchor_x),
		.anchor_y (anchor_y),
		.anchor_z (anchor_z),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.dir_z    (dir_z)
	);

	npl_score #(.COORD_BITS(COORD_BITS)) u_score (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.point_x  (point_x),
		.point_y  (point_y),
		.point_z  (point_z),
		.last     (last),
		.anchor_x (anchor_x),
		.anchor_y (anchor_y),
		.anchor_z (anchor_z),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.dir_z    (dir_z),
		.push     (push),
		.score    (push_score),
		.pt_x     (push_x),
		.pt_y     (push_y),
		.pt_z     (push_z),
		.pt_last  (push_last)
	);

	npl_queue #(.COORD_BITS(COORD_BITS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.reserve    (accept),
		.push       (push),
		.push_score (push_score),
		.push_x     (push_x),
		.push_y     (push_y),
		.push_z     (push_z),
		.push_last  (push_last),
		.pop        (pop),
		.full       (q_full),
		.not_empty  (q_valid),
		.head_score (head_score),
		.head_x     (head_x),
		.head_y     (head_y),
		.head_z     (head_z),
		.head_last  (head_last)
	);

	npl_select #(.COORD_BITS(COORD_BITS)) u_select (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_score (head_score),
		.head_x     (head_x),
		.head_y     (head_y),
		.head_z     (head_z),
		.head_last  (head_last),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.near_x     (near_x),
		.near_y     (near_y),
		.near_z     (near_z)
	);

endmodule

`default_nettype wire

### verif/tb_nearest_point_to_line.sv
// Testbench for nearest_point_to_line: streams point sets and checks each set's nearest point.
`default_nettype none

module tb_nearest_point_to_line;
	timeunit 1ns;
	timeprecision 1ps;

	import npl_pkg::*;

	localparam int CB = 16;
	localparam int SETTLE_CYCLES = 16;
	localparam int FIRST_UNUSED_REG = 6;
	localparam int MAX_REPORTS = 10;
	localparam int RESET_CYCLES = 12;

	typedef logic signed [CB-1:0] coord_t;
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;
	logic last;
	logic out_valid;
	logic out_stall = 1'b0;
	coord_t near_x;
	coord_t near_y;
	coord_t near_z;

	coord_t line_cfg [FIRST_UNUSED_REG];
	logic [127:0] best_score;
	logic have_best;
	point_t best_point;
	point_t nearest_q [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;

	nearest_point_to_line #(.COORD_BITS(CB)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.near_x(near_x),
		.near_y(near_y),
		.near_z(near_z)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	function automatic logic [127:0] line_score(point_t p);
		logic signed [63:0] hx, hy, hz, dx, dy, dz, cx, cy, cz;
		logic signed [127:0] sum;
		hx = $signed(p.x) - $signed(line_cfg[REG_ANCHOR_X]);
		hy = $signed(p.y) - $signed(line_cfg[REG_ANCHOR_Y]);
		hz = $signed(p.z) - $signed(line_cfg[REG_ANCHOR_Z]);
		dx = $signed(line_cfg[REG_DIR_X]);
		dy = $signed(line_cfg[REG_DIR_Y]);
		dz = $signed(line_cfg[REG_DIR_Z]);
		cx = dy * hz - dz * hy;
		cy = dz * hx - dx * hz;
		cz = dx * hy - dy * hx;
		sum = cx * cx + cy * cy + cz * cz;
		return sum;
	endfunction

	// The first point of a set, or one with a strictly smaller score, becomes the winner.
	function automatic void track_nearest(point_t p, logic set_end);
		logic [127:0] score;
		score = line_score(p);
		if (!have_best || score < best_score) begin
			best_score = score;
			have_best = 1'b1;
			best_point = p;
		end
		if (set_end) begin
			nearest_q.push_back(best_point);
			best_score = '0;
			have_best = 1'b0;
			best_point = '0;
		end
	endfunction

	always @(negedge clk) begin
		point_t got;
		point_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {near_x, near_y, near_z};
			if (nearest_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("Unexpected result transfer (%0d,%0d,%0d).",
						$signed(got.x), $signed(got.y), $signed(got.z));
			end else begin
				want = nearest_q.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("Nearest point mismatch: expected (%0d,%0d,%0d), got (%0d,%0d,%0d).",
							$signed(want.x), $signed(want.y), $signed(want.z),
							$signed(got.x), $signed(got.y), $signed(got.z));
				end
			end
		end
	end

	task automatic send_point(point_t p, logic set_end);
		bit taken;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= p.x;
		point_y <= p.y;
		point_z <= p.z;
		last <= set_end;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		track_nearest(p, set_end);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (nearest_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(int idx, logic [DATA_BITS-1:0] data);
		bit ready;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'(4 * idx);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			ready = pready;
			@(posedge clk);
		end while (!ready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < FIRST_UNUSED_REG)
			line_cfg[idx] = data[CB-1:0];
		@(posedge clk);
	endtask

	task automatic apb_read(int idx, output logic [DATA_BITS-1:0] data);
		bit ready;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_BITS'(4 * idx);
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			ready = pready;
			data = prdata;
			@(posedge clk);
		end while (!ready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_coord(reg_idx_t r, coord_t v);
		logic [31:0] upper;
		upper = $urandom;
		apb_write(r, {upper[31:16], v});
	endtask

	task automatic set_line(coord_t ax, coord_t ay, coord_t az, coord_t dx, coord_t dy,
		coord_t dz);
		drain_results();
		write_coord(REG_ANCHOR_X, ax);
		write_coord(REG_ANCHOR_Y, ay);
		write_coord(REG_ANCHOR_Z, az);
		write_coord(REG_DIR_X, dx);
		write_coord(REG_DIR_Y, dy);
		write_coord(REG_DIR_Z, dz);
	endtask

	function automatic coord_t pick_extreme();
		case ($urandom_range(0, 3))
			0: return coord_t'(16'h8000);
			1: return coord_t'(16'h7FFF);
			2: return coord_t'(0);
			default: return coord_t'(16'hFFFF);
		endcase
	endfunction

	function automatic coord_t rand_coord(coord_t center);
		case ($urandom_range(0, 4))
			0, 1: return coord_t'($urandom);
			2: return center + coord_t'($urandom_range(0, 64)) - coord_t'(32);
			3: return pick_extreme();
			default: return coord_t'($urandom_range(0, 16)) - coord_t'(8);
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		coord_t k;
		if ($urandom_range(0, 5) == 0) begin
			k = coord_t'($urandom_range(0, 6)) - coord_t'(3);
			p.x = line_cfg[REG_ANCHOR_X] + k * line_cfg[REG_DIR_X];
			p.y = line_cfg[REG_ANCHOR_Y] + k * line_cfg[REG_DIR_Y];
			p.z = line_cfg[REG_ANCHOR_Z] + k * line_cfg[REG_DIR_Z];
		end else begin
			p.x = rand_coord(line_cfg[REG_ANCHOR_X]);
			p.y = rand_coord(line_cfg[REG_ANCHOR_Y]);
			p.z = rand_coord(line_cfg[REG_ANCHOR_Z]);
		end
		return p;
	endfunction

	function automatic coord_t rand_cfg_value();
		case ($urandom_range(0, 4))
			0, 1: return coord_t'($urandom);
			2: return pick_extreme();
			3: return coord_t'($urandom_range(0, 8)) - coord_t'(4);
			default: return coord_t'(0);
		endcase
	endfunction

	task automatic load_random_line();
		coord_t v [FIRST_UNUSED_REG];
		bit zero_dir;
		zero_dir = ($urandom_range(0, 7) == 0);
		foreach (v[i])
			v[i] = rand_cfg_value();
		if (zero_dir) begin
			v[REG_DIR_X] = '0;
			v[REG_DIR_Y] = '0;
			v[REG_DIR_Z] = '0;
		end
		set_line(v[REG_ANCHOR_X], v[REG_ANCHOR_Y], v[REG_ANCHOR_Z],
			v[REG_DIR_X], v[REG_DIR_Y], v[REG_DIR_Z]);
	endtask

	task automatic send_random_set(int n);
		for (int i = 0; i < n; i++)
			send_point(rand_point(), i == n - 1);
	endtask

	task automatic test_reset_line();
		send_point('{16'sd100, 16'sd3, 16'sd4}, 1'b0);
		send_point('{-16'sd5, 16'sd0, 16'sd5}, 1'b0);
		send_point('{16'sd7, -16'sd2, 16'sd1}, 1'b0);
		send_point('{16'sh7FFF, 16'sh8000, 16'sd0}, 1'b1);
		send_point('{16'sh8000, 16'sh8000, 16'sh8000}, 1'b1);
	endtask

	task automatic test_register_access();
		coord_t vals [FIRST_UNUSED_REG];
		logic [DATA_BITS-1:0] rd;
		vals = '{16'sh8000, 16'sh7FFF, -16'sd1, 16'sd0, 16'sh8000, 16'sh7FFF};
		set_line(vals[0], vals[1], vals[2], vals[3], vals[4], vals[5]);
		apb_write(FIRST_UNUSED_REG, $urandom);
		apb_write(FIRST_UNUSED_REG + 1, $urandom);
		foreach (vals[i]) begin
			apb_read(i, rd);
			if (rd[CB-1:0] !== vals[i]) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("Register %0d read back %h, expected %h.", i, rd[CB-1:0], vals[i]);
			end
		end
		send_point('{16'sh7FFF, 16'sh8000, 16'sh7FFF}, 1'b0);
		send_point('{16'sd0, 16'sd0, 16'sd0}, 1'b1);
	endtask

	task automatic test_extreme_values();
		set_line(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
		send_point('{16'sh7FFF, 16'sh8000, 16'sh7FFF}, 1'b0);
		send_point('{16'sh8000, 16'sh7FFF, 16'sh8000}, 1'b0);
		send_point('{-16'sd1, -16'sd1, -16'sd1}, 1'b1);
		set_line(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000);
		send_point('{16'sh8000, 16'sh8000, 16'sh7FFF}, 1'b0);
		send_point('{16'sh8000, 16'sh7FFF, 16'sh8000}, 1'b0);
		send_point('{16'sd0, 16'sd0, 16'sd0}, 1'b1);
	endtask

	task automatic test_zero_direction();
		set_line(16'sd12, -16'sd7, 16'sd3, 16'sd0, 16'sd0, 16'sd0);
		send_point('{16'sh7FFF, 16'sd5, -16'sd9}, 1'b0);
		send_point('{16'sd12, -16'sd7, 16'sd3}, 1'b0);
		send_point('{16'sh8000, 16'sh8000, 16'sh8000}, 1'b1);
	endtask

	task automatic test_score_ties();
		set_line(16'sd1, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd5);
		send_point('{16'sd2, 16'sd1, 16'sd9}, 1'b0);
		send_point('{16'sd1, 16'sd2, -16'sd7}, 1'b0);
		send_point('{16'sd0, 16'sd1, 16'sd3}, 1'b0);
		send_point('{16'sd1, 16'sd1, 16'sd100}, 1'b0);
		send_point('{16'sd1, 16'sd1, -16'sd100}, 1'b1);
	endtask

	// Output stalls back up the queue; the sender then holds off until all expected results are out.
	task automatic test_backpressure_drain();
		load_random_line();
		send_idle_pct = 0;
		recv_idle_pct = 90;
		repeat (12) send_random_set($urandom_range(1, 3));
		in_valid <= 1'b0;
		while (nearest_q.size() != 0)
			@(posedge clk);
		recv_idle_pct = 0;
		repeat (4) send_random_set($urandom_range(1, 3));
	endtask

	task automatic run_random_phase(int send_pct, int recv_pct, int items);
		int sent;
		int since_cfg;
		int n;
		drain_results();
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		since_cfg = 0;
		while (sent < items) begin
			if (since_cfg == 0)
				load_random_line();
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
			send_random_set(n);
			sent += n;
			since_cfg += n;
			if (since_cfg >= 60)
				since_cfg = 0;
		end
	endtask

	task automatic test_random_streams();
		run_random_phase(38, 52, 250);
		run_random_phase(52, 38, 250);
		run_random_phase(0, 0, 250);
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		point_x <= '0;
		point_y <= '0;
		point_z <= '0;
		last <= 1'b0;
		line_cfg = '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0};
		best_score = '0;
		have_best = 1'b0;
		best_point = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 38;
		recv_idle_pct = 52;
		test_reset_line();
		test_register_access();
		test_extreme_values();
		test_zero_direction();
		test_score_ties();
		test_backpressure_drain();
		test_random_streams();
		drain_results();
		if (fail_count == 0 && nearest_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
